FILE: rtl/ksc_pkg.sv
// Shared types, constants and widths for the keyed slot cache.
package ksc_pkg;

	localparam int KEY_W        = 48;
	localparam int OFF_W        = 24;
	localparam int SLOT_W       = 15;
	localparam int ENTRIES_DEF  = 1024;

	localparam logic [SLOT_W-1:0] SLOT_BYTES_RST = 15'd6496;
	localparam logic [OFF_W:0]    MEM_TOP        = 25'h100_0000;

	localparam logic ACT_LOOKUP = 1'b0;
	localparam logic ACT_INSERT = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [OFF_W-1:0] offset;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CALC,
		ST_WRITE,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/ksc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ksc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/keyed_slot_cache_round_robin.sv
// Fully associative key directory with round-robin replacement, top level.
// Scan: a transaction scans the filled entries one per cycle through a single compare unit:
//   a lookup or insert hit ends the scan at the hit, a miss reads every filled entry, and an
//   insert miss then adds the offset multiply, then the subtract and write.
// Throughput: one transaction at a time; the next request is taken once the sequencer is idle again.
// Reset: arst_n clears the fill count, victim pointer, sequencer and slot_bytes (6496) at once;
//   entries at or above the fill count count as invalid, so no clearing pass runs after reset.
module keyed_slot_cache_round_robin
	import ksc_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration: slot_bytes
	input  logic              cfg_we,
	input  logic [SLOT_W-1:0] cfg_wdata,
	// request channel
	input  logic              req_valid,
	output logic              req_ready,
	input  logic              action,
	input  logic [KEY_W-1:0]  key,
	// response channel
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic              found,
	output logic              inserted,
	output logic [OFF_W-1:0]  slot_offset
);

	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = IDX_W + 1;
	localparam int MUL_W   = SLOT_W + CNT_W;
	localparam int PROD_W  = (MUL_W > OFF_W) ? MUL_W : OFF_W;
	localparam logic [CNT_W-1:0] FULL     = CNT_W'(ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	state_t state_q, state_d;

	// Control state
	logic [SLOT_W-1:0] slot_bytes_q;
	logic [CNT_W-1:0]  fill_q;      // entries [0, fill_q) are valid
	logic [IDX_W-1:0]  victim_q;
	logic [CNT_W-1:0]  scan_idx_q;  // next index to read
	logic              pend_s1;     // RAM read data belongs to the scan
	logic              rsp_valid_q;

	// Transaction payload
	logic              act_q;
	logic [KEY_W-1:0]  key_q;
	logic [OFF_W-1:0]  prod_q;
	logic              res_found_q, res_ins_q;
	logic [OFF_W-1:0]  res_off_q;
	logic              out_found_q, out_ins_q;
	logic [OFF_W-1:0]  out_off_q;

	// Datapath
	logic              req_acc;
	logic              issue;
	logic              match;
	logic              scan_end;
	logic              out_free;
	logic              wr_en;
	logic [CNT_W-1:0]  victim_inc;
	logic [PROD_W-1:0] prod_full;
	logic [OFF_W-1:0]  wr_off;
	entry_t            wr_entry;
	entry_t            rd_entry;
	logic [$bits(entry_t)-1:0] rd_data;

	assign req_ready = (state_q == ST_IDLE);
	assign req_acc   = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;

	// Scan: one read per cycle while unread valid entries remain; the compare sees the
	// registered read data in the next cycle.
	assign issue    = (state_q == ST_SCAN) && (scan_idx_q < fill_q);
	assign rd_entry = entry_t'(rd_data);
	assign match    = pend_s1 && (rd_entry.key == key_q);
	assign scan_end = !issue && !pend_s1;

	// Offset = top of memory minus slot_bytes * (victim + 1), modulo 2^24.
	assign victim_inc = CNT_W'(victim_q) + CNT_W'(1);
	assign prod_full  = PROD_W'(slot_bytes_q) * PROD_W'(victim_inc);
	assign wr_off     = OFF_W'(MEM_TOP - (OFF_W + 1)'(prod_q));

	assign wr_en           = (state_q == ST_WRITE);
	assign wr_entry.key    = key_q;
	assign wr_entry.offset = wr_off;

	ksc_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (victim_q),
		.wdata (wr_entry),
		.re    (issue),
		.raddr (scan_idx_q[IDX_W-1:0]),
		.rdata (rd_data)
	);

	// Sequencer: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (match) begin
					state_d = ST_DONE;
				end else if (scan_end) begin
					state_d = (act_q == ACT_INSERT) ? ST_CALC : ST_DONE;
				end
			end
			ST_CALC: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_bytes_q <= SLOT_BYTES_RST;
			fill_q       <= '0;
			victim_q     <= '0;
			scan_idx_q   <= '0;
			pend_s1      <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				slot_bytes_q <= cfg_wdata;
			end
			if (req_acc) begin
				scan_idx_q <= '0;
				pend_s1    <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				scan_idx_q <= scan_idx_q + CNT_W'(issue);
				pend_s1    <= issue;
			end
			if (wr_en) begin
				victim_q <= (victim_q == LAST_IDX) ? '0 : victim_q + IDX_W'(1);
				if (fill_q != FULL) begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end
			if ((state_q == ST_DONE) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (req_acc) begin
			act_q <= action;
			key_q <= key;
		end
		if (state_q == ST_SCAN) begin
			if (match) begin
				res_found_q <= 1'b1;
				res_ins_q   <= 1'b0;
				res_off_q   <= (act_q == ACT_INSERT) ? '0 : rd_entry.offset;
			end else if (scan_end) begin
				res_found_q <= 1'b0;
				res_ins_q   <= 1'b0;
				res_off_q   <= '0;
			end
		end
		if (state_q == ST_CALC) begin
			prod_q <= prod_full[OFF_W-1:0];
		end
		if (wr_en) begin
			res_found_q <= 1'b0;
			res_ins_q   <= 1'b1;
			res_off_q   <= wr_off;
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_found_q <= res_found_q;
			out_ins_q   <= res_ins_q;
			out_off_q   <= res_off_q;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign found       = out_found_q;
	assign inserted    = out_ins_q;
	assign slot_offset = out_off_q;

	// Fill count never passes the capacity.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL)
		else $error("fill count above capacity");

	// Until the directory is full, the victim is the first unwritten entry.
	a_victim_tracks_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != FULL) |-> (CNT_W'(victim_q) == fill_q))
		else $error("victim pointer out of step with fill count");

	// The scan never reads beyond the valid entries.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scan_idx_q <= fill_q)
		else $error("scan index beyond fill count");

	// Each write grows the fill count by one until full.
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (fill_q == $past(fill_q) + CNT_W'(1)) || (fill_q == FULL))
		else $error("fill count did not advance on write");

	// A response is loaded only from the final state of the sequencer.
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("response raised outside the done state");

endmodule

FILE: tb/sv/keyed_slot_cache_round_robin_tb.sv
// Randomized self-checking testbench for the keyed slot cache directory.
`timescale 1ns / 1ps

module keyed_slot_cache_round_robin_tb;
	import ksc_pkg::*;

	// Run the directory at its full default depth so every offset and scan
	// matches the block as it is used.
	localparam int TB_ENTRIES   = ENTRIES_DEF;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 58;
	localparam int MAX_GAP      = 5;

	// Expected response of one transaction, packed so it compares and clears as a whole.
	typedef struct packed {
		logic             found;
		logic             inserted;
		logic [OFF_W-1:0] offset;
	} dir_rsp_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [SLOT_W-1:0] cfg_wdata = '0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	logic              action    = ACT_LOOKUP;
	logic [KEY_W-1:0]  key       = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	logic              found;
	logic              inserted;
	logic [OFF_W-1:0]  slot_offset;

	// Shadow copy of the directory, kept in step with every accepted request.
	logic [KEY_W-1:0]  dir_key   [TB_ENTRIES];
	logic [OFF_W-1:0]  dir_off   [TB_ENTRIES];
	bit                dir_valid [TB_ENTRIES];
	int unsigned       victim       = 0;
	int unsigned       fill         = 0;
	logic [SLOT_W-1:0] slot_bytes_q = SLOT_BYTES_RST;

	dir_rsp_t          pending_rsp[$];
	logic [KEY_W-1:0]  evicted_keys[$];

	bit tx_gaps    = 1'b1;
	bit rx_gaps    = 1'b1;
	int stall_left = 0;

	int fails   = 0;
	int n_req   = 0;
	int n_rsp   = 0;
	int n_hits  = 0;
	int n_ins   = 0;
	int n_evict = 0;
	int n_cfg   = 0;

	keyed_slot_cache_round_robin #(
		.ENTRIES(TB_ENTRIES)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.action     (action),
		.key        (key),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.found      (found),
		.inserted   (inserted),
		.slot_offset(slot_offset)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Apply one request to the shadow directory and return what the block must answer.
	// The search takes the first valid match in index order; an insert miss claims the
	// victim slot at offset 2^24 - slot_bytes * (victim + 1), reduced modulo 2^24.
	function automatic dir_rsp_t dir_access(logic act, logic [KEY_W-1:0] k);
		dir_rsp_t         r;
		int               hit;
		logic [OFF_W-1:0] off;
		r   = '0;
		hit = -1;
		for (int i = 0; i < TB_ENTRIES; i++)
			if (hit < 0 && dir_valid[i] && dir_key[i] == k)
				hit = i;
		if (hit >= 0) begin
			// An insert of a present key reports the hit but leaves offset at zero.
			r.found = 1'b1;
			if (act == ACT_LOOKUP)
				r.offset = dir_off[hit];
			n_hits++;
		end else if (act == ACT_INSERT) begin
			off = OFF_W'(64'(MEM_TOP) - 64'(slot_bytes_q) * 64'(victim + 1));
			// Replacing a live entry drops its key; remember it to probe for misses later.
			if (dir_valid[victim]) begin
				evicted_keys.push_back(dir_key[victim]);
				if (evicted_keys.size() > 64)
					void'(evicted_keys.pop_front());
				n_evict++;
			end
			dir_key[victim]   = k;
			dir_off[victim]   = off;
			dir_valid[victim] = 1'b1;
			victim = (victim + 1) % TB_ENTRIES;
			if (fill < TB_ENTRIES)
				fill++;
			r.inserted = 1'b1;
			r.offset   = off;
			n_ins++;
		end
		return r;
	endfunction

	function automatic logic [KEY_W-1:0] rand_key();
		return KEY_W'({$urandom, $urandom});
	endfunction

	// Entries fill from index 0 upward, so every index below fill holds a live key.
	function automatic logic [KEY_W-1:0] known_key();
		return dir_key[$urandom_range(0, fill - 1)];
	endfunction

	// Send one request transaction. Valid is left high after acceptance so a
	// back-to-back request only changes the payload at the next falling edge.
	task automatic send_req(logic act, logic [KEY_W-1:0] k);
		int gap;
		gap = tx_gaps ? $urandom_range(0, MAX_GAP) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		action    <= act;
		key       <= k;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		pending_rsp.push_back(dir_access(act, k));
		n_req++;
	endtask

	// Drop valid and hold until every outstanding response has come back.
	task automatic quiesce();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	// Write slot_bytes only with the block idle; the shadow copy follows at once.
	task automatic set_slot_bytes(logic [SLOT_W-1:0] v);
		quiesce();
		@(negedge clk);
		cfg_we       <= 1'b1;
		cfg_wdata    <= v;
		slot_bytes_q = v;
		n_cfg++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Response side: draw a stall for each result, counted only while valid is up.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_ready <= 1'b0;
			if (rsp_valid)
				stall_left--;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// Compare every accepted response against the oldest expectation, field by field.
	always @(posedge clk) begin
		dir_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			n_rsp++;
			if (pending_rsp.size() == 0) begin
				$error("response with no request pending: found=%0d inserted=%0d slot_offset=%0h",
					found, inserted, slot_offset);
				fails++;
			end else begin
				want = pending_rsp.pop_front();
				if (found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, found);
					fails++;
				end
				if (inserted !== want.inserted) begin
					$error("inserted: expected %0d, got %0d", want.inserted, inserted);
					fails++;
				end
				if (slot_offset !== want.offset) begin
					$error("slot_offset: expected %06h, got %06h", want.offset, slot_offset);
					fails++;
				end
			end
			stall_left = rx_gaps ? $urandom_range(0, MAX_GAP) : 0;
		end
	end

	// Empty directory after reset, and the reset value of slot_bytes in the first offset.
	task automatic test_after_reset();
		send_req(ACT_LOOKUP, '0);
		send_req(ACT_LOOKUP, '1);
		send_req(ACT_INSERT, 48'h0123_4567_89AB);
		send_req(ACT_LOOKUP, 48'h0123_4567_89AB);
	endtask

	// All-zero and all-one keys, single-bit neighbors that must miss, and an
	// insert of a key already present.
	task automatic test_key_extremes();
		send_req(ACT_INSERT, '0);
		send_req(ACT_INSERT, '1);
		send_req(ACT_LOOKUP, '0);
		send_req(ACT_LOOKUP, '1);
		send_req(ACT_LOOKUP, 48'h0000_0000_0001);
		send_req(ACT_LOOKUP, 48'h7FFF_FFFF_FFFF);
		send_req(ACT_LOOKUP, 48'h8000_0000_0000);
		send_req(ACT_INSERT, '1);
		send_req(ACT_INSERT, 48'h0123_4567_89AB);
	endtask

	// slot_bytes at its extremes: zero wraps the offset to zero, so a later lookup
	// must show found with a zero offset; then the largest value, one and 16384, and back to reset.
	task automatic test_slot_bytes_extremes();
		set_slot_bytes('0);
		send_req(ACT_INSERT, 48'hA5A5_5A5A_C3C3);
		set_slot_bytes('1);
		send_req(ACT_INSERT, 48'h5A5A_A5A5_3C3C);
		set_slot_bytes(SLOT_W'(1));
		send_req(ACT_INSERT, 48'hFFFF_0000_FFFF);
		set_slot_bytes(SLOT_W'(16384));
		send_req(ACT_INSERT, 48'h0000_FFFF_0000);
		send_req(ACT_LOOKUP, 48'hA5A5_5A5A_C3C3);
		send_req(ACT_LOOKUP, 48'h5A5A_A5A5_3C3C);
		set_slot_bytes(SLOT_BYTES_RST);
	endtask

	// Phases of random traffic, each under its own slot_bytes and idle pattern.
	// About half the requests insert, so the scans grow long, though the directory never fills;
	// the lookups target live keys, evicted keys if any, one-bit neighbors and random keys.
	task automatic test_random();
		int               sel;
		logic [KEY_W-1:0] k;
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				case ($urandom_range(0, 5))
					0: begin
						set_slot_bytes('0);
					end
					1: begin
						set_slot_bytes('1);
					end
					2: begin
						set_slot_bytes(SLOT_W'(1));
					end
					3: begin
						set_slot_bytes(SLOT_W'(16384));
					end
					default: begin
						set_slot_bytes(SLOT_W'($urandom));
					end
				endcase
			end
			// Leave some phases free of idle cycles on one or both sides.
			tx_gaps = ($urandom_range(0, 3) != 0);
			rx_gaps = ($urandom_range(0, 3) != 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				sel = $urandom_range(0, 99);
				if (sel < 35 || fill == 0) begin
					send_req(ACT_INSERT, rand_key());
				end else if (sel < 50) begin
					send_req(ACT_INSERT, known_key());
				end else if (sel < 78) begin
					send_req(ACT_LOOKUP, known_key());
				end else if (sel < 86 && evicted_keys.size() != 0) begin
					send_req(ACT_LOOKUP, evicted_keys[$urandom_range(0, evicted_keys.size() - 1)]);
				end else if (sel < 93) begin
					k = known_key();
					k[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
					send_req(ACT_LOOKUP, k);
				end else begin
					send_req(ACT_LOOKUP, rand_key());
				end
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_after_reset();
		test_key_extremes();
		test_slot_bytes_extremes();
		test_random();

		// Drain, then watch long enough for a full scan to catch any stray response.
		tx_gaps = 1'b0;
		quiesce();
		repeat (TB_ENTRIES + 10) @(posedge clk);

		$display("Ran %0d requests (%0d responses) over %0d slot_bytes writes:",
			n_req, n_rsp, n_cfg);
		$display("  %0d hits, %0d new entries, %0d evictions of live entries",
			n_hits, n_ins, n_evict);
		if (fails == 0) begin
			$display("keyed_slot_cache_round_robin test passed");
		end else begin
			$display("keyed_slot_cache_round_robin test failed");
		end
		$finish;
	end

	// Hard stop: far beyond the slowest correct run.
	initial begin
		#40_000_000;
		$display("keyed_slot_cache_round_robin test failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/ksc_pkg.sv
rtl/ksc_ram.sv
rtl/keyed_slot_cache_round_robin.sv
tb/sv/keyed_slot_cache_round_robin_tb.sv
